// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, quiet while reset is asserted.
`define PR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form of the check above.
`define PR_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    `PR_ASSERT(label, clk, rst_n, (pre) |-> (post), msg)

`endif

// ===== design/pr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pr_pkg
// Types, codes and helpers shared by the packet router modules.
// ----------------------------------------------------------------------------
package pr_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] TYPE_HUB     = 8'h09;
    localparam logic [7:0] TYPE_UPLINK  = 8'h18;
    localparam logic [7:0] TYPE_ACTION  = 8'h25;
    localparam logic [7:0] BYTE_DESC    = 8'h0a;
    localparam logic [7:0] BYTE_HUB_LEN = 8'h02;
    localparam logic [7:0] BYTE_LED_ON  = 8'h01;
    localparam logic [7:0] UPLINK_COUNT = 8'd8;

    localparam logic [1:0] KIND_DOWN = 2'd0;
    localparam logic [1:0] KIND_UP   = 2'd1;
    localparam logic [1:0] KIND_LED  = 2'd2;

    localparam logic CFG_IDENTITY = 1'b0;
    localparam logic CFG_EXTRA    = 1'b1;

    localparam logic [3:0] HUB_LAST_IDX = 4'd11;

    typedef enum logic [2:0] {
        PH_LEN,
        PH_TYPE,
        PH_UPRELAY,
        PH_ADDR,
        PH_LED,
        PH_DNRELAY
    } phase_t;

    typedef enum logic [1:0] {
        CMD_BEAT,
        CMD_HUB,
        CMD_UPHDR,
        CMD_FWD
    } cmd_op_t;

    // One queued job for the back end
    typedef struct packed {
        cmd_op_t     op;
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        led;
        logic [2:0]  held;
        logic [31:0] addr;
    } cmd_t;

    // Byte sel of a word, sel 0 being the most significant byte
    function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] sel);
        logic [4:0] lsb;
        lsb = 5'(6'd24 - {1'b0, sel, 3'b000});
        return w[lsb +: 8];
    endfunction

endpackage

// ===== design/module_packet_router.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// module_packet_router
// Length-then-type frame parser with hub reply, relay and LED control.
// ----------------------------------------------------------------------------
// The parser takes one byte per cycle whenever the job queue has room; bytes that
// cause no result or a single result keep that rate end to end unless the output
// stalls. A hub query turns into twelve output beats, a type 0x18 header into two,
// and a forwarded action frame into two to six; the beat generator emits one beat
// per cycle unless the output stalls, so a reply holds its job slot until its last
// beat is loaded, and the input stalls only once the job queue (QUEUE_DEPTH
// entries) fills behind it. Results leave through a registered output stage.
module module_packet_router
    import pr_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] tx_byte, [8] led_level, rest zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0] identity_reg;
    logic [31:0] extra_reg;

    logic q_push, q_space, q_pop, q_avail;
    cmd_t q_cmd, q_head;

    logic [7:0] tx_byte;
    logic       led_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            identity_reg <= 32'd1;
            extra_reg    <= 32'h0001_0001;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDENTITY: identity_reg <= cfg_data;
                CFG_EXTRA:    extra_reg    <= cfg_data;
                default:      extra_reg    <= extra_reg;
            endcase
        end
    end

    pr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_byte  (s_axis_tdata),
        .in_ready (s_axis_tready),
        .identity (identity_reg),
        .q_space  (q_space),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    pr_cmd_fifo #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .space    (q_space),
        .pop      (q_pop),
        .avail    (q_avail),
        .head     (q_head)
    );

    pr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_avail    (q_avail),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .identity   (identity_reg),
        .extra_info (extra_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_kind   (m_axis_tuser),
        .out_byte   (tx_byte),
        .out_led    (led_level),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, led_level, tx_byte};

endmodule

// ===== design/pr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pr_front
// Frame parser: takes one received byte per beat and queues the jobs it causes.
// ----------------------------------------------------------------------------
module pr_front
    import pr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [7:0]  in_byte,
    output logic        in_ready,
    input  logic [31:0] identity,
    input  logic        q_space,
    output logic        q_push,
    output cmd_t        q_cmd
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  left_reg, left_next;
    logic [31:0] hold_reg, hold_next;
    logic [1:0]  count_reg, count_next;

    logic        accept;
    logic [31:0] addr_shift;
    logic        addr_done;
    logic        addr_match;
    logic [7:0]  body;
    logic [2:0]  held;
    logic [7:0]  rest;

    assign in_ready   = q_space;
    assign accept     = in_valid && q_space;
    assign addr_shift = {hold_reg[23:0], in_byte};
    assign addr_done  = (count_reg == 2'd3);
    assign addr_match = (addr_shift == identity);
    assign body       = (len_reg >= 8'd2) ? 8'(len_reg - 8'd2) : 8'd0;
    assign held       = (body < 8'd4) ? body[2:0] : 3'd4;
    assign rest       = 8'(body - {5'b0, held});

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        hold_next  = hold_reg;
        count_next = count_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    len_next   = in_byte;
                    phase_next = PH_TYPE;
                end
                PH_TYPE:
                begin
                    phase_next = PH_LEN;
                    if (in_byte == TYPE_UPLINK)
                    begin
                        left_next  = UPLINK_COUNT;
                        phase_next = PH_UPRELAY;
                    end
                    else if (in_byte == TYPE_ACTION)
                    begin
                        hold_next  = '0;
                        count_next = '0;
                        phase_next = PH_ADDR;
                    end
                end
                PH_UPRELAY, PH_DNRELAY:
                begin
                    left_next = 8'(left_reg - 8'd1);
                    if (left_reg == 8'd1)
                        phase_next = PH_LEN;
                end
                PH_ADDR:
                begin
                    hold_next  = addr_shift;
                    count_next = 2'(count_reg + 2'd1);
                    if (addr_done)
                    begin
                        if (addr_match)
                            phase_next = PH_LED;
                        else
                        begin
                            left_next  = rest;
                            phase_next = (rest != 8'd0) ? PH_DNRELAY : PH_LEN;
                        end
                    end
                end
                PH_LED:
                    phase_next = PH_LEN;
                default:
                    phase_next = PH_LEN;
            endcase
        end
    end

    always_comb
    begin
        q_push = 1'b0;
        q_cmd  = '{op: CMD_BEAT, kind: KIND_DOWN, data: in_byte, led: 1'b0,
                   held: held, addr: addr_shift};
        case (phase_reg)
            PH_TYPE:
            begin
                if (in_byte == TYPE_HUB)
                begin
                    q_push   = accept;
                    q_cmd.op = CMD_HUB;
                end
                else if (in_byte == TYPE_UPLINK)
                begin
                    q_push   = accept;
                    q_cmd.op = CMD_UPHDR;
                end
            end
            PH_UPRELAY:
            begin
                q_push     = accept;
                q_cmd.kind = KIND_UP;
            end
            PH_DNRELAY:
                q_push = accept;
            PH_ADDR:
            begin
                q_push     = accept && addr_done && !addr_match;
                q_cmd.op   = CMD_FWD;
                q_cmd.data = len_reg;
            end
            PH_LED:
            begin
                q_push     = accept;
                q_cmd.kind = KIND_LED;
                q_cmd.data = 8'd0;
                q_cmd.led  = (in_byte == BYTE_LED_ON);
            end
            default:
                q_push = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEN;
            len_reg   <= '0;
            left_reg  <= '0;
            hold_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            hold_reg  <= hold_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/pr_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pr_cmd_fifo
// Short register queue of jobs between the parser and the beat generator.
// ----------------------------------------------------------------------------
module pr_cmd_fifo
    import pr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic space,
    input  logic pop,
    output logic avail,
    output cmd_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t            slot_reg [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    assign space = (cnt_reg != CW'(DEPTH));
    assign avail = (cnt_reg != '0);
    assign head  = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_reg + 1'b1);
        if (pop)
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_reg + 1'b1);
        if (push && !pop)
            cnt_next = CW'(cnt_reg + 1'b1);
        else if (pop && !push)
            cnt_next = CW'(cnt_reg - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== design/pr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pr_back
// Beat generator: expands each queued job into output beats, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module pr_back
    import pr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_avail,
    input  cmd_t        q_head,
    output logic        q_pop,
    input  logic [31:0] identity,
    input  logic [31:0] extra_info,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  out_kind,
    output logic [7:0]  out_byte,
    output logic        out_led,
    output logic        out_last
);

    logic [3:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [1:0] kind_reg;
    logic [7:0] byte_reg;
    logic       led_reg;
    logic       last_reg;

    logic       advance;
    logic       load;
    logic [1:0] b_kind;
    logic [7:0] b_byte;
    logic       b_led;
    logic       b_last;
    logic [1:0] sel;

    assign advance = !valid_reg || out_ready;
    assign load    = advance && q_avail;
    assign q_pop   = load && b_last;
    // Descriptor words start at beat two and six; both map to byte zero
    assign sel     = 2'(idx_reg[1:0] + 2'd2);

    always_comb
    begin
        b_kind = q_head.kind;
        b_byte = q_head.data;
        b_led  = q_head.led;
        b_last = 1'b1;
        case (q_head.op)
            CMD_BEAT:
                b_last = 1'b1;
            CMD_HUB:
            begin
                b_led  = 1'b0;
                b_last = (idx_reg == HUB_LAST_IDX);
                b_kind = KIND_UP;
                if (idx_reg == 4'd0)
                    b_byte = BYTE_DESC;
                else if (idx_reg == 4'd1)
                    b_byte = TYPE_UPLINK;
                else if (idx_reg < 4'd6)
                    b_byte = word_byte(identity, sel);
                else if (idx_reg < 4'd10)
                    b_byte = word_byte(extra_info, sel);
                else
                begin
                    b_kind = KIND_DOWN;
                    b_byte = (idx_reg == 4'd10) ? BYTE_HUB_LEN : TYPE_HUB;
                end
            end
            CMD_UPHDR:
            begin
                b_kind = KIND_UP;
                b_led  = 1'b0;
                b_byte = (idx_reg == 4'd0) ? BYTE_DESC : TYPE_UPLINK;
                b_last = (idx_reg == 4'd1);
            end
            CMD_FWD:
            begin
                b_kind = KIND_DOWN;
                b_led  = 1'b0;
                b_last = (idx_reg == 4'({1'b0, q_head.held} + 4'd1));
                if (idx_reg == 4'd0)
                    b_byte = q_head.data;
                else if (idx_reg == 4'd1)
                    b_byte = TYPE_ACTION;
                else
                    b_byte = word_byte(q_head.addr, sel);
            end
            default:
                b_last = 1'b1;
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (advance)
            valid_next = q_avail;
        if (load)
            idx_next = b_last ? 4'd0 : 4'(idx_reg + 4'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= b_kind;
            byte_reg <= b_byte;
            led_reg  <= b_led;
            last_reg <= b_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_byte  = byte_reg;
    assign out_led   = led_reg;
    assign out_last  = last_reg;

endmodule

// ===== design/pr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pr_checker
// Port-level checks on the router's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pr_checker
    import pr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // hold a stalled beat
    `PR_ASSERT_IMPL(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, ##1 m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled beat changed")
    `PR_ASSERT_IMPL(a_kind_code, clk, rst_n, m_axis_tvalid, m_axis_tuser == KIND_DOWN || m_axis_tuser == KIND_UP || m_axis_tuser == KIND_LED, "undefined kind")
    // LED update is always a single, byte-free beat
    `PR_ASSERT_IMPL(a_led_beat, clk, rst_n, m_axis_tvalid && m_axis_tuser == KIND_LED, m_axis_tdata[7:0] == 8'd0 && m_axis_tlast, "bad LED beat")
    `PR_ASSERT_IMPL(a_led_only_led, clk, rst_n, m_axis_tvalid && m_axis_tuser != KIND_LED, !m_axis_tdata[8] && m_axis_tdata[15:9] == 7'd0, "level bit on data beat")

endmodule

bind module_packet_router pr_checker u_pr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/router_reply_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// router_reply_checker
// Watches the router's byte stream, result stream and register writes.
// ----------------------------------------------------------------------------
// Every accepted rx beat goes through a frame parser that mirrors the router.
// The result beats that the byte should cause are queued in order. Each
// accepted result beat is compared field by field with the oldest queued
// beat. Failures are counted and handed to the testbench top.
module router_reply_checker
    import pr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [7:0] tx_byte, [8] led_level, rest zero
    input  logic [1:0]  m_axis_tuser,   // [1:0] kind
    input  logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          replies_pending,
    output int          replies_checked
);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tx;
        logic       led;
        logic       last;
    } reply_t;

    reply_t      expected_replies[$];
    reply_t      want;
    int          burst_len;

    // Parser state and register copies
    phase_t      phase;
    logic [7:0]  frame_len;
    logic [7:0]  bytes_left;
    logic [31:0] addr_hold;
    logic [2:0]  addr_count;
    logic [31:0] identity;
    logic [31:0] extra_info;

    // Byte i of a word, byte 0 being the most significant
    function automatic logic [7:0] byte_of(input logic [31:0] w, input int i);
        return w[31 - 8 * i -: 8];
    endfunction

    task automatic stage(input logic [1:0] kind, input logic [7:0] tx, input logic led);
        expected_replies.push_back(reply_t'{kind, tx, led, 1'b0});
        burst_len++;
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        reply_t tail;
        int     body;
        int     held;
        burst_len = 0;
        case (phase)
            PH_LEN:
            begin
                frame_len = b;
                phase = PH_TYPE;
            end
            PH_TYPE:
            begin
                phase = PH_LEN;
                if (b == TYPE_HUB)
                begin
                    stage(KIND_UP, BYTE_DESC, 1'b0);
                    stage(KIND_UP, TYPE_UPLINK, 1'b0);
                    for (int i = 0; i < 4; i++)
                        stage(KIND_UP, byte_of(identity, i), 1'b0);
                    for (int i = 0; i < 4; i++)
                        stage(KIND_UP, byte_of(extra_info, i), 1'b0);
                    stage(KIND_DOWN, BYTE_HUB_LEN, 1'b0);
                    stage(KIND_DOWN, TYPE_HUB, 1'b0);
                end
                else if (b == TYPE_UPLINK)
                begin
                    stage(KIND_UP, BYTE_DESC, 1'b0);
                    stage(KIND_UP, TYPE_UPLINK, 1'b0);
                    bytes_left = UPLINK_COUNT;
                    phase = PH_UPRELAY;
                end
                else if (b == TYPE_ACTION)
                begin
                    addr_hold = '0;
                    addr_count = '0;
                    phase = PH_ADDR;
                end
            end
            PH_UPRELAY:
            begin
                stage(KIND_UP, b, 1'b0);
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'd0)
                    phase = PH_LEN;
            end
            PH_ADDR:
            begin
                addr_hold = {addr_hold[23:0], b};
                addr_count = addr_count + 3'd1;
                if (addr_count >= 3'd4)
                begin
                    addr_count = '0;
                    if (addr_hold == identity)
                        phase = PH_LED;
                    else
                    begin
                        // Forward downstream; short frames drop part of the address
                        body = (frame_len >= 8'd2) ? int'(frame_len) - 2 : 0;
                        held = (body < 4) ? body : 4;
                        stage(KIND_DOWN, frame_len, 1'b0);
                        stage(KIND_DOWN, TYPE_ACTION, 1'b0);
                        for (int i = 0; i < held; i++)
                            stage(KIND_DOWN, byte_of(addr_hold, i), 1'b0);
                        bytes_left = 8'(body - held);
                        phase = (bytes_left != 8'd0) ? PH_DNRELAY : PH_LEN;
                    end
                end
            end
            PH_LED:
            begin
                stage(KIND_LED, 8'h00, b == BYTE_LED_ON);
                phase = PH_LEN;
            end
            PH_DNRELAY:
            begin
                stage(KIND_DOWN, b, 1'b0);
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'd0)
                    phase = PH_LEN;
            end
            default:
                phase = PH_LEN;
        endcase
        if (burst_len > 0)
        begin
            tail = expected_replies.pop_back();
            tail.last = 1'b1;
            expected_replies.push_back(tail);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase = PH_LEN;
            frame_len = '0;
            bytes_left = '0;
            addr_hold = '0;
            addr_count = '0;
            identity = 32'h0000_0001;
            extra_info = 32'h0001_0001;
            expected_replies.delete();
            fail_count = 0;
            replies_pending = 0;
            replies_checked = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_IDENTITY)
                    identity = cfg_data;
                else if (cfg_index == CFG_EXTRA)
                    extra_info = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                parse_rx_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: unexpected result beat, kind %0d data %04h last %0d",
                             $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    fail_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    replies_checked++;
                    if (m_axis_tuser !== want.kind)
                    begin
                        $display("%0t: kind mismatch, expected %0d actual %0d",
                                 $time, want.kind, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tdata[7:0] !== want.tx)
                    begin
                        $display("%0t: tx_byte mismatch, expected %02h actual %02h",
                                 $time, want.tx, m_axis_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[8] !== want.led)
                    begin
                        $display("%0t: led_level mismatch, expected %0d actual %0d",
                                 $time, want.led, m_axis_tdata[8]);
                        fail_count++;
                    end
                    if (m_axis_tdata[15:9] !== 7'd0)
                    begin
                        $display("%0t: tdata padding mismatch, expected 00 actual %02h",
                                 $time, m_axis_tdata[15:9]);
                        fail_count++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $display("%0t: last mismatch, expected %0d actual %0d",
                                 $time, want.last, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            replies_pending = expected_replies.size();
        end
    end

endmodule

// ===== tb/module_packet_router_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// module_packet_router_tb
// Frame stimulus, handshake pressure and verdict for the packet router.
// ----------------------------------------------------------------------------
// Sends a short directed set of frames, then random frames in four handshake
// phases (no idling, sender idle, receiver stalling, both), changing both
// registers between phases. Checking is done by router_reply_checker.
module module_packet_router_tb;
    import pr_pkg::*;

    localparam int HOLD_CYCLES   = 64;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS   = 34;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;     // [7:0] tx_byte, [8] led_level, rest zero
    logic [1:0]  m_axis_tuser;     // [1:0] kind
    logic        m_axis_tlast;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    int          fail_count;
    int          replies_pending;
    int          replies_checked;

    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_req;
    int          bytes_sent;
    logic [31:0] identity;
    logic [31:0] extra_info;

    always #1 clk = ~clk;

    module_packet_router dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    router_reply_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .replies_pending (replies_pending),
        .replies_checked (replies_checked)
    );

    // Result side: random stalls, plus a long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat
    // is taken, with tvalid still high.
    task automatic offer_byte(input logic [7:0] b);
        // Idle each cycle with the phase's probability
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_random_frame();
        int          pick;
        int          len;
        int          body;
        int          rest;
        logic [31:0] addr;
        logic [7:0]  kind_byte;
        pick = $urandom_range(99);
        if (pick < 14)
        begin
            offer_byte(8'($urandom));
            offer_byte(TYPE_HUB);
        end
        else if (pick < 28)
        begin
            offer_byte(8'($urandom));
            offer_byte(TYPE_UPLINK);
            repeat (8) offer_byte(8'($urandom));
        end
        else if (pick < 48)
        begin
            // Addressed here: length byte is ignored, LED byte follows the address
            offer_byte(($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12)));
            offer_byte(TYPE_ACTION);
            for (int k = 0; k < 4; k++)
                offer_byte(identity[31 - 8 * k -: 8]);
            offer_byte($urandom_range(1) ? BYTE_LED_ON : 8'($urandom));
        end
        else if (pick < 70)
        begin
            // Foreign address, often a near miss; rarely a very long frame
            len = ($urandom_range(49) == 0) ? $urandom_range(200, 255)
                                            : $urandom_range(0, 14);
            addr = $urandom;
            if ($urandom_range(1) || addr == identity)
                addr = identity ^ (32'h1 << $urandom_range(31));
            offer_byte(8'(len));
            offer_byte(TYPE_ACTION);
            for (int k = 0; k < 4; k++)
                offer_byte(addr[31 - 8 * k -: 8]);
            body = (len >= 2) ? len - 2 : 0;
            rest = (body > 4) ? body - 4 : 0;
            repeat (rest) offer_byte(8'($urandom));
        end
        else if (pick < 85)
        begin
            kind_byte = 8'($urandom);
            while (kind_byte == TYPE_HUB || kind_byte == TYPE_UPLINK
                   || kind_byte == TYPE_ACTION)
                kind_byte = 8'($urandom);
            offer_byte(8'($urandom));
            offer_byte(kind_byte);
        end
        else
        begin
            // Noise: throws the parser out of frame alignment
            repeat ($urandom_range(1, 3)) offer_byte(8'($urandom));
        end
    endtask

    // Drop tvalid and wait until every expected result is out and the
    // job queue has had time to empty of bytes that cause none.
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (replies_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int target;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        cfg_we = 1'b0;
        cfg_index = CFG_IDENTITY;
        cfg_data = 32'h0;
        hold_req = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        bytes_sent = 0;
        identity = 32'h0000_0001;
        extra_info = 32'h0001_0001;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                1:
                begin
                    identity = 32'h0000_0000;
                    extra_info = 32'h0000_0000;
                    send_idle_pct = 47;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    identity = 32'hffff_ffff;
                    extra_info = 32'hffff_ffff;
                    send_idle_pct = 0;
                    recv_stall_pct = 47;
                end
                3:
                begin
                    identity = $urandom;
                    extra_info = $urandom;
                    send_idle_pct = 8;
                    recv_stall_pct = 8;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            if (ph != 0)
            begin
                write_reg(CFG_IDENTITY, identity);
                write_reg(CFG_EXTRA, extra_info);
            end
            else
            begin
                // Hub query with the reset descriptor
                offer_byte(8'h02);
                offer_byte(TYPE_HUB);
                // Uplink relay with extreme and code-like body bytes
                offer_byte(8'hff);
                offer_byte(TYPE_UPLINK);
                offer_byte(8'h00);
                offer_byte(8'hff);
                offer_byte(8'h55);
                offer_byte(8'haa);
                offer_byte(TYPE_HUB);
                offer_byte(TYPE_ACTION);
                offer_byte(8'h80);
                offer_byte(8'h01);
                // Short action frame for this module: length zero still takes the LED byte
                offer_byte(8'h00);
                offer_byte(TYPE_ACTION);
                for (int k = 0; k < 4; k++)
                    offer_byte(identity[31 - 8 * k -: 8]);
                offer_byte(BYTE_LED_ON);
                // Foreign action frame of length one: header only, address dropped
                offer_byte(8'h01);
                offer_byte(TYPE_ACTION);
                repeat (4) offer_byte(8'hff);
                // Hold the result side while hub queries keep coming
                hold_req = 1'b1;
                repeat (6)
                begin
                    offer_byte(BYTE_HUB_LEN);
                    offer_byte(TYPE_HUB);
                end
            end
            target = bytes_sent + PHASE_ITEMS;
            while (bytes_sent < target)
                send_random_frame();
            settle_idle();
        end

        $display("Sent %0d rx beats over four handshake phases, each with its own",
                 bytes_sent);
        $display("identity and descriptor; checked %0d result beats, %0d outstanding.",
                 replies_checked, replies_pending);
        if (fail_count == 0 && replies_pending == 0)
            $display("module_packet_router verification clean");
        else
            $display("module_packet_router verification failed");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Timeout with %0d result beats outstanding", replies_pending);
        $display("module_packet_router verification failed");
        $finish;
    end

endmodule
